// ===== rtl/mdl_pkg.sv =====
package mdl_pkg;

	localparam int FILTER_TAPS_DEF = 8;

	localparam int POS_W   = 10;
	localparam int SAMP_W  = 12;
	localparam int GAIN_W  = 8;
	localparam int LEVEL_W = 13;
	localparam int DRV_W   = 9;
	localparam int MEAS_W  = 14;
	localparam int DUTY_W  = 8;
	localparam int FILT_W  = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// shared multiplier and divider
	localparam int MA_W  = 15;
	localparam int MB_W  = 12;
	localparam int MP_W  = 27;
	localparam int DIV_W = 25;
	localparam int DVS_W = 11;
	localparam int TGT_W = 26;

	localparam int MEAS_MAX_TRQ = 12000;
	localparam int MEAS_MAX_SPD = 1200;
	localparam int SPD_DIV      = 10;
	localparam int DRV_MUL      = 17;
	localparam int DRV_DIV      = 5;
	localparam int ERR_SAT_TRQ  = 75;
	localparam int ERR_SAT_SPD  = 511;
	localparam int DUTY_MAX     = 255;
	localparam int TURBO_CODE   = 256;
	localparam int FILT_RST     = 512;

	localparam int GAIN_RST  = 1;
	localparam int HLO_RST   = 0;
	localparam int HHI_RST   = 1023;
	localparam int LLO_RST   = 0;
	localparam int LHI_RST   = 400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_SENSE_GAIN = 3'd1,
		REG_HAMMER_LO  = 3'd2,
		REG_HAMMER_HI  = 3'd3,
		REG_LEVEL_LO   = 3'd4,
		REG_LEVEL_HI   = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_MEAS,
		ST_DMEAS,
		ST_TGT,
		ST_TGT2,
		ST_TGT3,
		ST_DTGT,
		ST_ERR,
		ST_DDRV,
		ST_FILT,
		ST_DFILT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/mdl_if.sv =====
interface mdl_in_if import mdl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  hammer_pos;
	logic [SAMP_W-1:0] current_sample;
	logic [SAMP_W-1:0] voltage_sample;
	logic              choke_on;

	modport source (output valid, hammer_pos, current_sample, voltage_sample, choke_on,
		input ready);
	modport sink (input valid, hammer_pos, current_sample, voltage_sample, choke_on,
		output ready);
endinterface

interface mdl_out_if import mdl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DRV_W-1:0]  drive_level;
	logic              turbo;
	logic [MEAS_W-1:0] measured_value;

	modport source (output valid, drive_level, turbo, measured_value, input ready);
	modport sink (input valid, drive_level, turbo, measured_value, output ready);
endinterface

// ===== rtl/mdl_div.sv =====
module mdl_div import mdl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// restoring, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/mdl_ram.sv =====
module mdl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/motor_drive_loop_with_output_filter.sv =====
// The sequencer runs a 25-step shared divider up to three times per sample (speed scaling,
// pedal map, drive /5 in torque mode, filter average) plus one shared 15x12 multiplier.
// Only one sample is in flight at a time; ready rises again once the result is
// registered, which waits while the previous result beat stalls.
// Reset (arst_n low, async): registers to defaults, filter value 512, ring empty.
module motor_drive_loop_with_output_filter import mdl_pkg::*; #(
	parameter int FILTER_TAPS = FILTER_TAPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	mdl_in_if.sink                sample_ch,
	mdl_out_if.source             result_ch
);

	localparam int SLOT_W = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
	localparam int SUM_W  = $clog2(FILTER_TAPS * DUTY_MAX + 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FILTER_TAPS - 1);
	localparam logic [DVS_W-1:0]  TAP_DIV   = DVS_W'(FILTER_TAPS + 1);

	state_t state_q, state_d;

	logic               mode_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [POS_W-1:0]   hlo_q, hhi_q;
	logic [LEVEL_W-1:0] llo_q, lhi_q;

	logic [POS_W-1:0]   pos_q;
	logic [SAMP_W-1:0]  cur_q, volt_q;
	logic               choke_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_q;
	logic signed [MP_W-1:0] acc_q;
	logic signed [MP_W-1:0] num;
	logic [MP_W-1:0]        num_mag;

	logic [MEAS_W-1:0]       meas_q;
	logic signed [TGT_W-1:0] tgt_q;
	logic signed [TGT_W:0]   err;
	logic                    err_pos;
	logic                    neg_q;
	logic [DUTY_W-1:0]       drv_q;
	logic [10:0]             err17;

	logic [SUM_W-1:0]  sum_q, sum_new;
	logic [FILT_W-1:0] fv_q;
	logic [SLOT_W-1:0] slot_q;
	logic              wrap_q;
	logic [DUTY_W-1:0] ram_rdata;
	logic [DUTY_W-1:0] old_val;
	logic              ram_we;

	logic signed [MA_W-1:0] llo_s, lhi_s, ylo, yhi, dy;
	logic signed [MB_W-1:0] span_s, dpos;
	logic                   span_pos;
	logic [SAMP_W+5:0]      spd_diff;
	logic [DIV_W-1:0]       quo;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              out_valid_q;
	logic [DRV_W-1:0]  out_lvl_q;
	logic              out_turbo_q;
	logic [MEAS_W-1:0] out_meas_q;
	logic              out_load;
	logic [DRV_W-1:0]  lvl;
	logic              turbo;

	mdl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mdl_ram #(
		.WIDTH (DUTY_W),
		.DEPTH (FILTER_TAPS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (drv_q),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			gain_q <= GAIN_W'(GAIN_RST);
			hlo_q  <= POS_W'(HLO_RST);
			hhi_q  <= POS_W'(HHI_RST);
			llo_q  <= LEVEL_W'(LLO_RST);
			lhi_q  <= LEVEL_W'(LHI_RST);
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_MODE:       mode_q <= cfg_wdata[0];
				REG_SENSE_GAIN: gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_HAMMER_LO:  hlo_q  <= cfg_wdata[POS_W-1:0];
				REG_HAMMER_HI:  hhi_q  <= cfg_wdata[POS_W-1:0];
				REG_LEVEL_LO:   llo_q  <= cfg_wdata[LEVEL_W-1:0];
				REG_LEVEL_HI:   lhi_q  <= cfg_wdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// target range, mirrored in speed mode
	assign llo_s    = $signed({2'b00, llo_q});
	assign lhi_s    = $signed({2'b00, lhi_q});
	assign ylo      = mode_q ? (MA_W'(MEAS_MAX_SPD) - lhi_s) : llo_s;
	assign yhi      = mode_q ? (MA_W'(MEAS_MAX_SPD) - llo_s) : lhi_s;
	assign dy       = yhi - ylo;
	assign span_s   = $signed({2'b00, hhi_q}) - $signed({2'b00, hlo_q});
	assign dpos     = $signed({2'b00, pos_q}) - $signed({2'b00, hlo_q});
	assign span_pos = hhi_q > hlo_q;

	assign quo      = div_rsp.quotient;
	assign num      = acc_q + mul_q;
	assign num_mag  = num[MP_W-1] ? MP_W'(-num) : MP_W'(num);
	assign spd_diff = {6'd0, volt_q} - quo[SAMP_W+5:0];
	assign err      = {tgt_q[TGT_W-1], tgt_q} - {{(TGT_W + 1 - MEAS_W){1'b0}}, meas_q};
	assign err_pos  = !err[TGT_W] && (err != '0);
	assign err17    = 11'(err[6:0]) * 11'(DRV_MUL);
	assign old_val  = wrap_q ? ram_rdata : '0;
	assign sum_new  = sum_q - SUM_W'(old_val) + SUM_W'(drv_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PROD: begin
				mul_a = $signed({3'b000, cur_q});
				mul_b = $signed({4'b0000, gain_q});
			end
			ST_TGT: begin
				mul_a = ylo;
				mul_b = span_s;
			end
			ST_TGT2: begin
				mul_a = dy;
				mul_b = dpos;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= MP_W'(mul_a) * MP_W'(mul_b);
	end

	// gating on the fresh filter value
	always_comb begin
		lvl   = (fv_q > FILT_W'(DUTY_MAX)) ? DRV_W'(DUTY_MAX) : DRV_W'(fv_q);
		turbo = 1'b0;
		if (pos_q <= hlo_q) begin
			lvl = '0;
		end
		if (choke_q && (pos_q >= hhi_q)) begin
			lvl   = DRV_W'(TURBO_CODE);
			turbo = 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		div_req  = '0;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_ch.valid) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: state_d = ST_MEAS;
			ST_MEAS: begin
				if (mode_q) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(mul_q[19:0]);
					div_req.divisor  = DVS_W'(SPD_DIV);
					state_d          = ST_DMEAS;
				end else begin
					state_d = ST_TGT;
				end
			end
			ST_DMEAS: begin
				if (div_rsp.done) begin
					state_d = ST_TGT;
				end
			end
			ST_TGT:  state_d = span_pos ? ST_TGT2 : ST_ERR;
			ST_TGT2: state_d = ST_TGT3;
			ST_TGT3: begin
				div_req.start    = 1'b1;
				div_req.dividend = num_mag[DIV_W-1:0];
				div_req.divisor  = DVS_W'(hhi_q - hlo_q);
				state_d          = ST_DTGT;
			end
			ST_DTGT: begin
				if (div_rsp.done) begin
					state_d = ST_ERR;
				end
			end
			ST_ERR: begin
				if (!mode_q && err_pos && (err <= ERR_SAT_TRQ)) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(err17);
					div_req.divisor  = DVS_W'(DRV_DIV);
					state_d          = ST_DDRV;
				end else begin
					state_d = ST_FILT;
				end
			end
			ST_DDRV: begin
				if (div_rsp.done) begin
					state_d = ST_FILT;
				end
			end
			ST_FILT: begin
				ram_we           = 1'b1;
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(fv_q) + DIV_W'(sum_new);
				div_req.divisor  = TAP_DIV;
				state_d          = ST_DFILT;
			end
			ST_DFILT: begin
				if (div_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fv_q   <= FILT_W'(FILT_RST);
			slot_q <= '0;
			wrap_q <= 1'b0;
		end else begin
			if (state_q == ST_FILT) begin
				sum_q <= sum_new;
			end
			if ((state_q == ST_DFILT) && div_rsp.done) begin
				fv_q <= quo[FILT_W-1:0];
				if (slot_q == SLOT_LAST) begin
					slot_q <= '0;
					wrap_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_ch.valid) begin
					pos_q   <= sample_ch.hammer_pos;
					cur_q   <= sample_ch.current_sample;
					volt_q  <= sample_ch.voltage_sample;
					choke_q <= sample_ch.choke_on;
				end
			end
			ST_MEAS: begin
				if (mul_q[19:0] >= 20'(MEAS_MAX_TRQ)) begin
					meas_q <= MEAS_W'(MEAS_MAX_TRQ);
				end else begin
					meas_q <= mul_q[MEAS_W-1:0];
				end
			end
			ST_DMEAS: begin
				if (div_rsp.done) begin
					if (spd_diff[SAMP_W+5]) begin
						meas_q <= '0;
					end else if (spd_diff >= (SAMP_W+6)'(MEAS_MAX_SPD)) begin
						meas_q <= MEAS_W'(MEAS_MAX_SPD);
					end else begin
						meas_q <= spd_diff[MEAS_W-1:0];
					end
				end
			end
			ST_TGT: begin
				if (!span_pos) begin
					tgt_q <= TGT_W'(ylo);
				end
			end
			ST_TGT2: acc_q <= mul_q;
			ST_TGT3: neg_q <= num[MP_W-1];
			ST_DTGT: begin
				if (div_rsp.done) begin
					tgt_q <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
				end
			end
			ST_ERR: begin
				if (!err_pos) begin
					drv_q <= '0;
				end else if (mode_q) begin
					drv_q <= (err > ERR_SAT_SPD) ? DUTY_W'(DUTY_MAX) : err[DUTY_W:1];
				end else if (err > ERR_SAT_TRQ) begin
					drv_q <= DUTY_W'(DUTY_MAX);
				end
			end
			ST_DDRV: begin
				if (div_rsp.done) begin
					drv_q <= quo[DUTY_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_lvl_q   <= lvl;
			out_turbo_q <= turbo;
			out_meas_q  <= meas_q;
		end
	end

	assign sample_ch.ready          = (state_q == ST_IDLE);
	assign result_ch.valid          = out_valid_q;
	assign result_ch.drive_level    = out_lvl_q;
	assign result_ch.turbo          = out_turbo_q;
	assign result_ch.measured_value = out_meas_q;

endmodule

// ===== rtl/mdl_checker.sv =====
module mdl_checker import mdl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DRV_W-1:0]  drive_level,
	input logic              turbo,
	input logic [MEAS_W-1:0] measured_value
);

	// one sample in flight
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input beat");

	a_turbo_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turbo == (drive_level == DRV_W'(TURBO_CODE))))
		else $error("turbo flag disagrees with drive level");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_level <= DRV_W'(TURBO_CODE))
			&& (measured_value <= MEAS_W'(MEAS_MAX_TRQ)))
		else $error("result beat out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_level)
			&& $stable(turbo) && $stable(measured_value))
		else $error("stalled result beat changed");

endmodule

bind motor_drive_loop_with_output_filter mdl_checker u_mdl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample_ch.valid),
	.in_ready       (sample_ch.ready),
	.out_valid      (result_ch.valid),
	.out_ready      (result_ch.ready),
	.drive_level    (result_ch.drive_level),
	.turbo          (result_ch.turbo),
	.measured_value (result_ch.measured_value)
);
